@@ rtl/bounded_fifo_with_stats_defines.svh @@
// Assertion macros shared by the bounded queue RTL.
`ifndef BOUNDED_FIFO_WITH_STATS_DEFINES_SVH
`define BOUNDED_FIFO_WITH_STATS_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define BFS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfs assertion failed");

// Next-cycle implication, checked outside reset.
`define BFS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfs assertion failed");

`else

`define BFS_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BFS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ rtl/bfs_pkg.sv @@
// Package: shared constants, opcodes and cell control type for the bounded queue.
`timescale 1ns / 1ps
package bfs_pkg;

    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;
    localparam int CFG_W              = 5;
    localparam int CNT_W              = 32;

    localparam logic [CFG_W-1:0] MAX_ENTRIES_RESET = CFG_W'(16);

    typedef enum logic {
        OP_ADD = 1'b0,
        OP_GET = 1'b1
    } t_op;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

@@ rtl/bfs_cell.sv @@
// One storage cell of the shifting queue chain.
`timescale 1ns / 1ps
module bfs_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int FILL_W     = 5,
    parameter int INDEX      = 0
) (
    input  logic                    i_clk,
    input  bfs_pkg::t_cell_ctrl     i_ctrl,
    input  logic [FILL_W-1:0]       i_fill,
    input  logic [DATA_WIDTH-1:0]   i_push_data,
    input  logic [DATA_WIDTH-1:0]   i_next_data,
    output logic [DATA_WIDTH-1:0]   o_data
);
    import bfs_pkg::*;

    logic [DATA_WIDTH-1:0] r_data;
    logic                  w_is_tail;

    // this cell is the first free slot
    assign w_is_tail = (i_fill == FILL_W'(INDEX));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push && w_is_tail) begin
            r_data <= i_push_data;
        end else if (i_ctrl.pop) begin
            r_data <= i_next_data;
        end
    end

    assign o_data = r_data;

endmodule

@@ rtl/bounded_fifo_with_stats.sv @@
// Top level: bounded queue built as a chain of shifting cells, with usage counters.
// The result strobes in the cycle after start is taken.
// Throughput: one item per cycle; busy is low out of reset, the chain shifts or loads in one step.
// The configuration write is taken in any cycle out of reset and is registered into the limit.
// Reset (synchronous, active low) clears fill level, counters and the limit (to 16) and holds
// busy high; cell contents are not reset. The receiver cannot stall the result.
`timescale 1ns / 1ps
`include "bounded_fifo_with_stats_defines.svh"
module bounded_fifo_with_stats #(
    parameter int DEPTH      = bfs_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = bfs_pkg::DATA_WIDTH_DEFAULT,
    parameter int FILL_W     = $clog2(DEPTH + 1)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // command channel
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_operation,
    input  logic signed [DATA_WIDTH-1:0]  i_value_in,
    // result channel
    output logic                          o_result_valid,
    output logic                          o_ok,
    output logic signed [DATA_WIDTH-1:0]  o_value_out,
    output logic [FILL_W-1:0]             o_occupancy,
    output logic [bfs_pkg::CNT_W-1:0]     o_add_tries,
    output logic [bfs_pkg::CNT_W-1:0]     o_get_tries,
    output logic [bfs_pkg::CNT_W-1:0]     o_adds_done,
    output logic [bfs_pkg::CNT_W-1:0]     o_gets_done,
    // configuration channel
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bfs_pkg::CFG_W-1:0]     i_cfg_data
);
    import bfs_pkg::*;

    localparam int CMP_W = (FILL_W > CFG_W) ? FILL_W : CFG_W;

    logic [CFG_W-1:0]      r_max_entries;
    logic [FILL_W-1:0]     r_fill, n_fill;
    logic [CNT_W-1:0]      r_add_tries, n_add_tries;
    logic [CNT_W-1:0]      r_get_tries, n_get_tries;
    logic [CNT_W-1:0]      r_adds_done, n_adds_done;
    logic [CNT_W-1:0]      r_gets_done, n_gets_done;
    logic                  r_result_valid;
    logic                  r_ok, n_ok;
    logic [DATA_WIDTH-1:0] r_value_out, n_value_out;

    logic                  w_accept;
    logic                  w_is_add;
    logic                  w_can_add;
    logic                  w_can_get;
    t_cell_ctrl            w_ctrl;
    logic [DATA_WIDTH-1:0] w_cell_data [DEPTH];

    // Commands never stall; hold both ports off only while in reset.
    assign busy        = !i_rst_n;
    assign o_cfg_ready = i_rst_n;
    assign w_accept    = start && !busy;
    assign w_is_add    = (t_op'(i_operation) == OP_ADD);

    // Room left: below the physical depth and below the programmed limit.
    assign w_can_add = (r_fill < FILL_W'(DEPTH)) &&
                       (CMP_W'(r_fill) < CMP_W'(r_max_entries));
    assign w_can_get = (r_fill != '0);

    assign w_ctrl.push = w_accept && w_is_add && w_can_add;
    assign w_ctrl.pop  = w_accept && !w_is_add && w_can_get;

    // Cell 0 holds the oldest item; a pop shifts every cell one place
    // towards the head, a push loads the cell at the current fill level.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_next;
        if (g == DEPTH - 1) begin : g_last
            assign w_next = w_cell_data[g];
        end else begin : g_mid
            assign w_next = w_cell_data[g + 1];
        end
        bfs_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .FILL_W     (FILL_W),
            .INDEX      (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_fill      (r_fill),
            .i_push_data (i_value_in),
            .i_next_data (w_next),
            .o_data      (w_cell_data[g])
        );
    end

    // Next state of fill level, counters and the result fields.
    always_comb begin
        n_fill      = r_fill;
        n_add_tries = r_add_tries;
        n_get_tries = r_get_tries;
        n_adds_done = r_adds_done;
        n_gets_done = r_gets_done;
        n_ok        = 1'b0;
        n_value_out = '0;
        if (w_accept) begin
            if (w_is_add) begin
                n_add_tries = r_add_tries + 1'b1;
                if (w_can_add) begin
                    n_fill      = r_fill + 1'b1;
                    n_adds_done = r_adds_done + 1'b1;
                    n_ok        = 1'b1;
                end
            end else begin
                n_get_tries = r_get_tries + 1'b1;
                if (w_can_get) begin
                    n_fill      = r_fill - 1'b1;
                    n_gets_done = r_gets_done + 1'b1;
                    n_ok        = 1'b1;
                    n_value_out = w_cell_data[0];
                end
            end
        end
    end

    // Control state and counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_entries  <= MAX_ENTRIES_RESET;
            r_fill         <= '0;
            r_add_tries    <= '0;
            r_get_tries    <= '0;
            r_adds_done    <= '0;
            r_gets_done    <= '0;
            r_result_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_max_entries <= i_cfg_data;
            end
            r_fill         <= n_fill;
            r_add_tries    <= n_add_tries;
            r_get_tries    <= n_get_tries;
            r_adds_done    <= n_adds_done;
            r_gets_done    <= n_gets_done;
            r_result_valid <= w_accept;
        end
    end

    // Result payload: hold only what is not already a state register.
    always_ff @(posedge i_clk) begin
        r_ok        <= n_ok;
        r_value_out <= n_value_out;
    end

    assign o_result_valid = r_result_valid;
    assign o_ok           = r_ok;
    assign o_value_out    = r_value_out;
    assign o_occupancy    = r_fill;
    assign o_add_tries    = r_add_tries;
    assign o_get_tries    = r_get_tries;
    assign o_adds_done    = r_adds_done;
    assign o_gets_done    = r_gets_done;

    // Checks
    `BFS_ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= FILL_W'(DEPTH))
    `BFS_ASSERT_NEXT(a_push_grows, i_clk, i_rst_n, w_ctrl.push, r_fill == $past(r_fill) + 1'b1)
    `BFS_ASSERT_NOW(a_fail_zero, i_clk, i_rst_n, o_result_valid && !o_ok, o_value_out == '0)
    `BFS_ASSERT_NEXT(a_one_result, i_clk, i_rst_n, w_accept, o_result_valid)

endmodule
